### sv/sfb_pkg.sv
`timescale 1ns / 1ps
// Package for the scrolling frame buffer: item field widths, operation codes,
// shift direction codes and the registered item type. No dependencies.
package sfb_pkg;

    localparam int SIDE_DEFAULT = 8;

    localparam int KIND_W   = 2;
    localparam int ROW_W    = 3;
    localparam int COL_W    = 3;
    localparam int PIXEL_W  = 8;
    localparam int DIR_W    = 2;
    localparam int STRIP_W  = 6;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SHIFT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
        logic [PIXEL_W-1:0] pixel_in;
        logic [DIR_W-1:0]   direction;
        logic [STRIP_W-1:0] strip_index;
    } t_item;

endpackage

### sv/sfb_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the scrolling frame buffer.
// Depends on sfb_pkg for the field widths.
interface sfb_in_if;
    logic                         valid;
    logic                         ready;
    logic [sfb_pkg::KIND_W-1:0]   kind;
    logic [sfb_pkg::ROW_W-1:0]    row;
    logic [sfb_pkg::COL_W-1:0]    column;
    logic [sfb_pkg::PIXEL_W-1:0]  pixel_in;
    logic [sfb_pkg::DIR_W-1:0]    direction;
    logic [sfb_pkg::STRIP_W-1:0]  strip_index;

    modport source (output valid, kind, row, column, pixel_in, direction, strip_index,
                    input ready);
    modport sink   (input valid, kind, row, column, pixel_in, direction, strip_index,
                    output ready);
endinterface

interface sfb_out_if;
    logic                         valid;
    logic                         ready;
    logic [sfb_pkg::PIXEL_W-1:0]  pixel_out;

    modport source (output valid, pixel_out, input ready);
    modport sink   (input valid, pixel_out, output ready);
endinterface

### sv/scrolling_frame_buffer_core.sv
`timescale 1ns / 1ps
// Top level of the scrolling frame buffer: frame registers, item register and
// result register. Depends on sfb_pkg and the channel interfaces in sfb_if.
//
// Usage: items arrive on the input channel (valid/ready); a transfer happens
// at a rising edge with both high. A write item stores pixel_in at (row,
// column); a shift item rotates the whole frame one step with wraparound and
// turns every nonzero pixel into 1; a read item returns the pixel at a
// serpentine strip position on the output channel. Unused kind codes, writes
// off the frame and shifts produce no result; a strip index past the chain
// returns 0.
// An accepted item is held in the item register and applied from there; a read
// result is registered in the result register and transfers on the output
// channel from there. Throughput is one item per cycle while no read waits
// behind a full result register: the frame is held in flip-flops, so a
// whole-frame rotate is a single register update.
// Reset (synchronous, active low) clears every pixel to zero and empties both
// registers. When the receiver stalls, the result register holds its value;
// writes and shifts keep flowing, and a read waiting behind a full result
// register holds the item register, which then drops input ready.
module scrolling_frame_buffer_core #(
    parameter int SIDE = sfb_pkg::SIDE_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfb_in_if.sink      i_in_ch,
    sfb_out_if.source   o_out_ch
);

    localparam int RW        = $clog2(SIDE);
    localparam int CELLS     = SIDE * SIDE;
    localparam int STRIP_N   = 2 ** sfb_pkg::STRIP_W;

    logic [sfb_pkg::PIXEL_W-1:0] r_frame [SIDE][SIDE];
    logic [sfb_pkg::PIXEL_W-1:0] n_frame [SIDE][SIDE];

    sfb_pkg::t_item              r_s1;
    logic                        r_s1_valid;
    logic                        r_out_valid;
    logic [sfb_pkg::PIXEL_W-1:0] r_out_pixel;

    logic                        w_in_fire;
    logic                        w_s1_is_read;
    logic                        w_s1_adv;
    logic                        w_s1_fire;
    logic [RW-1:0]               w_wr_row;
    logic [RW-1:0]               w_wr_col;
    logic                        w_wr_on_frame;
    logic [RW-1:0]               w_rd_row;
    logic [RW-1:0]               w_rd_col;
    logic                        w_rd_on_chain;
    logic [sfb_pkg::PIXEL_W-1:0] w_rd_pixel;
    logic                        w_frame_binary;

    // Constant decode tables from strip position to logical row and column.
    logic [RW-1:0] w_tab_row [STRIP_N];
    logic [RW-1:0] w_tab_col [STRIP_N];
    logic          w_tab_ok  [STRIP_N];

    genvar gi;
    generate
        for (gi = 0; gi < STRIP_N; gi++) begin : g_tab
            if (gi < CELLS) begin : g_on
                localparam int TC = gi / SIDE;
                localparam int TR = gi % SIDE;
                assign w_tab_col[gi] = RW'(TC);
                assign w_tab_row[gi] = (TC % 2 == 1) ? RW'(SIDE - 1 - TR) : RW'(TR);
                assign w_tab_ok[gi]  = 1'b1;
            end else begin : g_off
                assign w_tab_col[gi] = '0;
                assign w_tab_row[gi] = '0;
                assign w_tab_ok[gi]  = 1'b0;
            end
        end
    endgenerate

    assign w_s1_is_read = (r_s1.kind == sfb_pkg::KIND_READ);
    assign w_s1_adv     = !w_s1_is_read || !r_out_valid || o_out_ch.ready;
    assign w_s1_fire    = r_s1_valid && w_s1_adv;

    assign i_in_ch.ready = !r_s1_valid || w_s1_adv;
    assign w_in_fire     = i_in_ch.valid && i_in_ch.ready;

    assign w_wr_row      = RW'(r_s1.row);
    assign w_wr_col      = RW'(r_s1.column);
    assign w_wr_on_frame = (32'(r_s1.row) < SIDE) && (32'(r_s1.column) < SIDE);

    assign w_rd_row      = w_tab_row[r_s1.strip_index];
    assign w_rd_col      = w_tab_col[r_s1.strip_index];
    assign w_rd_on_chain = w_tab_ok[r_s1.strip_index];
    assign w_rd_pixel    = w_rd_on_chain ? r_frame[w_rd_row][w_rd_col] : '0;

    always_comb begin
        n_frame = r_frame;
        if (w_s1_fire) begin
            case (r_s1.kind)
                sfb_pkg::KIND_WRITE: begin
                    if (w_wr_on_frame) begin
                        n_frame[w_wr_row][w_wr_col] = r_s1.pixel_in;
                    end
                end
                sfb_pkg::KIND_SHIFT: begin
                    // Each destination pulls from its wrapped neighbor.
                    for (int r = 0; r < SIDE; r++) begin
                        for (int c = 0; c < SIDE; c++) begin
                            case (r_s1.direction)
                                sfb_pkg::DIR_RIGHT: n_frame[r][c] = sfb_pkg::PIXEL_W'(
                                    r_frame[r][(c == 0) ? SIDE - 1 : c - 1] != '0);
                                sfb_pkg::DIR_LEFT: n_frame[r][c] = sfb_pkg::PIXEL_W'(
                                    r_frame[r][(c == SIDE - 1) ? 0 : c + 1] != '0);
                                sfb_pkg::DIR_UP: n_frame[r][c] = sfb_pkg::PIXEL_W'(
                                    r_frame[(r == SIDE - 1) ? 0 : r + 1][c] != '0);
                                default: n_frame[r][c] = sfb_pkg::PIXEL_W'(
                                    r_frame[(r == 0) ? SIDE - 1 : r - 1][c] != '0);
                            endcase
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < SIDE; r++) begin
                for (int c = 0; c < SIDE; c++) begin
                    r_frame[r][c] <= '0;
                end
            end
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_frame <= n_frame;
            if (w_in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_fire && w_s1_is_read) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1.kind        <= i_in_ch.kind;
            r_s1.row         <= i_in_ch.row;
            r_s1.column      <= i_in_ch.column;
            r_s1.pixel_in    <= i_in_ch.pixel_in;
            r_s1.direction   <= i_in_ch.direction;
            r_s1.strip_index <= i_in_ch.strip_index;
        end
        if (w_s1_fire && w_s1_is_read) begin
            r_out_pixel <= w_rd_pixel;
        end
    end

    assign o_out_ch.valid     = r_out_valid;
    assign o_out_ch.pixel_out = r_out_pixel;

    always_comb begin
        w_frame_binary = 1'b1;
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                if (r_frame[r][c] > sfb_pkg::PIXEL_W'(1)) begin
                    w_frame_binary = 1'b0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    // A read blocked by a full result register keeps its item in place.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s1_adv |=> r_s1_valid && $stable(r_s1))
        else $error("stalled item register changed");

    // After a shift every pixel is zero or one.
    a_shift_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_fire && r_s1.kind == sfb_pkg::KIND_SHIFT |=> w_frame_binary)
        else $error("shift left a pixel above one");

    // A result only appears when a read item leaves the item register.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_s1_fire && w_s1_is_read))
        else $error("result without a read item");

    // Nothing but a read transfer from the item register ever writes the result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out_ch.ready && !(w_s1_fire && w_s1_is_read)
        |=> r_out_valid && $stable(r_out_pixel))
        else $error("pending result changed");
`endif

endmodule
